// File: hw/rtl/cursor_overlay_blender_top_assert.svh
// assertion helpers for the cursor overlay blender
`ifndef CURSOR_OVERLAY_BLENDER_TOP_ASSERT_SVH
`define CURSOR_OVERLAY_BLENDER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define COB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define COB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/cob_pkg.sv
package cob_pkg;

    localparam int CURSOR_EXTENT_DEF = 64;
    localparam int CURSOR_SIZE_RST   = 64;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 32;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_BLEND = 1'b1;

    typedef enum logic [2:0] {
        REG_LEFT   = 3'd0,
        REG_TOP    = 3'd1,
        REG_COLS   = 3'd2,
        REG_ROWS   = 3'd3,
        REG_SHOWN  = 3'd4,
        REG_FCOLS  = 3'd5,
        REG_FROWS  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] left;
        logic signed [31:0] top;
        logic [6:0]         cols;
        logic [6:0]         rows;
        logic               shown;
        logic [15:0]        fcols;
        logic [15:0]        frows;
    } t_cfg;

endpackage

// File: hw/rtl/cob_ram.sv
module cob_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/cob_regs.sv
module cob_regs import cob_pkg::*; #(
    parameter int CURSOR_EXTENT = CURSOR_EXTENT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output t_cfg                  o_cfg
);

    // largest size the 7-bit field can hold after clamping to the image extent
    localparam logic [6:0] SIZE_MAX = 7'((CURSOR_EXTENT > 127) ? 127 : CURSOR_EXTENT);
    localparam logic [6:0] SIZE_RST =
        7'((CURSOR_SIZE_RST > CURSOR_EXTENT) ? CURSOR_EXTENT : CURSOR_SIZE_RST);

    t_cfg       r_cfg;
    logic       wr_en;
    t_reg_idx   idx;
    logic [6:0] size_in;

    assign wr_en   = psel && penable && pwrite;
    assign idx     = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign size_in = (32'(pwdata[6:0]) > CURSOR_EXTENT) ? SIZE_MAX : pwdata[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left  <= '0;
            r_cfg.top   <= '0;
            r_cfg.cols  <= SIZE_RST;
            r_cfg.rows  <= SIZE_RST;
            r_cfg.shown <= 1'b0;
            r_cfg.fcols <= '0;
            r_cfg.frows <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_LEFT:  r_cfg.left  <= $signed(pwdata);
                REG_TOP:   r_cfg.top   <= $signed(pwdata);
                REG_COLS:  r_cfg.cols  <= size_in;
                REG_ROWS:  r_cfg.rows  <= size_in;
                REG_SHOWN: r_cfg.shown <= pwdata[0];
                REG_FCOLS: r_cfg.fcols <= pwdata[15:0];
                REG_FROWS: r_cfg.frows <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_LEFT:  prdata = r_cfg.left;
            REG_TOP:   prdata = r_cfg.top;
            REG_COLS:  prdata = {25'd0, r_cfg.cols};
            REG_ROWS:  prdata = {25'd0, r_cfg.rows};
            REG_SHOWN: prdata = {31'd0, r_cfg.shown};
            REG_FCOLS: prdata = {16'd0, r_cfg.fcols};
            REG_FROWS: prdata = {16'd0, r_cfg.frows};
            default:   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/cob_blend.sv
module cob_blend import cob_pkg::*; (
    input  logic        i_covered,
    input  logic [31:0] i_src,
    input  logic [31:0] i_dst,
    output logic [31:0] o_color
);

    logic [7:0]  alpha;
    logic [7:0]  inv;
    logic [7:0]  s_ch [3];
    logic [7:0]  d_ch [3];
    logic [15:0] prod [3];
    logic [16:0] rnd  [3];
    logic [16:0] quo  [3];
    logic [8:0]  sum  [3];
    logic [7:0]  mix  [3];

    assign alpha = i_src[31:24];
    assign inv   = 8'hff - alpha;

    // round(d*inv/255) via (t + (t >> 8)) >> 8 with t = d*inv + 128, exact over 8-bit range
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            s_ch[c] = i_src[8*c +: 8];
            d_ch[c] = i_dst[8*c +: 8];
            prod[c] = 16'(d_ch[c]) * 16'(inv);
            rnd[c]  = {1'b0, prod[c]} + 17'd128;
            quo[c]  = (rnd[c] + (rnd[c] >> 8)) >> 8;
            sum[c]  = {1'b0, s_ch[c]} + {1'b0, quo[c][7:0]};
            mix[c]  = sum[c][8] ? 8'hff : sum[c][7:0];
        end
    end

    always_comb begin
        if (!i_covered || alpha == 8'h00) begin
            o_color = i_dst;
        end else if (alpha == 8'hff) begin
            o_color = i_src;
        end else begin
            o_color = {8'hff, mix[2], mix[1], mix[0]};
        end
    end

endmodule

// File: hw/rtl/cursor_overlay_blender_top.sv
// cursor overlay blender
// input stream: each transaction is either a cursor image load (tuser = 0), which
// writes one premultiplied ARGB word at (image_row, image_col) and gives no output,
// or a frame pixel (tuser = 1), which gives exactly one output transaction carrying
// the blended pixel and a covered flag. output order follows input order.
// the APB port sets cursor position, size, visibility and frame size; write it only
// while no transactions are in flight.
// on the way from input acceptance to output valid, the accepting edge loads the input
// register, then the read stage (with the cursor store read) and the output register follow.
// throughput: one transaction per clock while the receiver keeps tready high, set by the
// single read port of the cursor store and a combinational blend stage.
// when the receiver holds tready low the output register keeps its data and the
// stages behind it fill; input tready drops once the input register is also full.
// synchronous reset empties the pipeline and restores register defaults; the cursor
// image is not cleared and must be loaded before it is shown.
`include "cursor_overlay_blender_top_assert.svh"

module cursor_overlay_blender_top import cob_pkg::*; #(
    parameter int CURSOR_EXTENT = CURSOR_EXTENT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // image_col[5:0], image_row[11:6], frame_x[27:12], frame_y[43:28],
    // pixel_color[75:44], zero pad[79:76]
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // req_type[0]
    input  logic [0:0]            i_s_tuser,
    // output stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // out_color[31:0]
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    // covered[0]
    output logic [0:0]            o_m_tuser
);

    localparam int IDX_W  = $clog2(CURSOR_EXTENT);
    localparam int ADDR_W = 2 * IDX_W;

    t_cfg cfg;

    cob_regs #(
        .CURSOR_EXTENT(CURSOR_EXTENT)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    assign pready = 1'b1;

    // handshake enables, back to front
    logic en_o;
    logic en_b;
    logic en_a;

    // input register
    logic        r_a_valid;
    logic        r_a_type;
    logic [5:0]  r_a_col;
    logic [5:0]  r_a_row;
    logic [15:0] r_a_fx;
    logic [15:0] r_a_fy;
    logic [31:0] r_a_color;

    // read stage
    logic        r_b_valid;
    logic        r_b_cov;
    logic [31:0] r_b_color;

    // output register
    logic        r_o_valid;
    logic        r_o_cov;
    logic [31:0] r_o_color;

    assign en_o       = !r_o_valid || i_m_tready;
    assign en_b       = !r_b_valid || en_o;
    assign en_a       = !r_a_valid || en_b;
    assign o_s_tready = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_type  <= i_s_tuser[0];
            r_a_col   <= i_s_tdata[5:0];
            r_a_row   <= i_s_tdata[11:6];
            r_a_fx    <= i_s_tdata[27:12];
            r_a_fy    <= i_s_tdata[43:28];
            r_a_color <= i_s_tdata[75:44];
        end
    end

    // cursor rectangle test on the signed offsets
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic               in_frame;
    logic               in_cursor;
    logic               hit;

    assign dx = $signed({18'd0, r_a_fx}) - $signed({{2{cfg.left[31]}}, cfg.left});
    assign dy = $signed({18'd0, r_a_fy}) - $signed({{2{cfg.top[31]}}, cfg.top});

    assign in_frame  = (r_a_fx < cfg.fcols) && (r_a_fy < cfg.frows);
    assign in_cursor = !dx[33] && !dy[33]
                       && (dx[32:0] < {26'd0, cfg.cols})
                       && (dy[32:0] < {26'd0, cfg.rows});
    assign hit       = cfg.shown && in_frame && in_cursor;

    // cursor store
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [31:0]       ram_rdata;
    logic              load_in_range;

    assign load_in_range = (32'(r_a_col) < CURSOR_EXTENT) && (32'(r_a_row) < CURSOR_EXTENT);
    assign ram_we        = r_a_valid && (r_a_type == REQ_LOAD) && load_in_range && en_b;
    assign ram_waddr     = {IDX_W'(r_a_row), IDX_W'(r_a_col)};
    assign ram_raddr     = {dy[IDX_W-1:0], dx[IDX_W-1:0]};

    cob_ram #(
        .WIDTH (32),
        .DEPTH (1 << ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_a_color),
        .i_re    (en_b),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= r_a_valid && (r_a_type == REQ_BLEND);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_cov   <= hit;
            r_b_color <= r_a_color;
        end
    end

    logic [31:0] blend_color;

    cob_blend u_blend (
        .i_covered (r_b_cov),
        .i_src     (ram_rdata),
        .i_dst     (r_b_color),
        .o_color   (blend_color)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en_o) begin
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_cov   <= r_b_cov;
            r_o_color <= blend_color;
        end
    end

    assign o_m_tvalid   = r_o_valid;
    assign o_m_tdata    = r_o_color;
    assign o_m_tuser[0] = r_o_cov;

    `COB_ASSERT_NXT(a_load_no_result, r_a_valid && (r_a_type == REQ_LOAD) && en_b,
        !r_b_valid, "cursor load produced a result")
    `COB_ASSERT_IMP(a_cov_needs_shown, r_o_valid && r_o_cov, cfg.shown,
        "covered pixel while cursor hidden")
    `COB_ASSERT_IMP(a_pass_through, r_b_valid && !r_b_cov, blend_color == r_b_color,
        "uncovered pixel was modified")
    `COB_ASSERT_IMP(a_empty_ready, !r_a_valid, o_s_tready,
        "input stalled with empty input register")

endmodule

// File: bench/cursor_overlay_blender_top_tb.sv
`timescale 1ns / 100ps

module cursor_overlay_blender_top_tb;
    import cob_pkg::*;

    localparam int          EXTENT       = CURSOR_EXTENT_DEF;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam logic [2:0]  REG_UNUSED   = 3'd7;

    typedef struct packed {
        logic [31:0] color;
        logic        covered;
    } t_overlay_px;

    typedef enum logic [1:0] {ROW_LOAD, ROW_BLEND, ROW_REG} t_row_kind;

    // load: a = col, b = row; blend: a = x, b = y; reg: a = index, color = value
    typedef struct {
        t_row_kind   kind;
        logic [15:0] a;
        logic [15:0] b;
        logic [31:0] color;
        logic        typed;
        logic [31:0] exp_color;
        logic        exp_cov;
    } t_row;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                 pready;
    logic                 s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 o_m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [0:0]           o_m_tuser;

    // shadow of the block's registers and cursor image
    logic signed [31:0] cur_left  = '0;
    logic signed [31:0] cur_top   = '0;
    logic [6:0]         cur_cols  = 7'd64;
    logic [6:0]         cur_rows  = 7'd64;
    logic               cur_shown = 1'b0;
    logic [15:0]        frm_cols  = '0;
    logic [15:0]        frm_rows  = '0;
    logic [31:0]        img_word [EXTENT*EXTENT];
    bit                 img_set  [EXTENT*EXTENT];

    t_overlay_px overlay_q[$];
    t_row        plan[$];

    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic rx_hold      = 1'b0;
    int   err_cnt      = 0;
    int   n_items      = 0;
    int   n_loads      = 0;
    int   n_out        = 0;
    int   n_cov        = 0;
    int   n_settings   = 0;
    int   cyc          = 0;
    event hold_kick;

    cursor_overlay_blender_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #1 i_clk = ~i_clk;

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_LEFT:  cur_left  = val;
            REG_TOP:   cur_top   = val;
            REG_COLS:  cur_cols  = (32'(val[6:0]) > EXTENT) ? 7'(EXTENT) : val[6:0];
            REG_ROWS:  cur_rows  = (32'(val[6:0]) > EXTENT) ? 7'(EXTENT) : val[6:0];
            REG_SHOWN: cur_shown = val[0];
            REG_FCOLS: frm_cols  = val[15:0];
            REG_FROWS: frm_rows  = val[15:0];
            default: ;
        endcase
    endfunction

    // image slot under the pixel, or -1 when the cursor does not cover it
    function automatic int cursor_slot(input logic [15:0] fx, input logic [15:0] fy);
        longint dx, dy;
        dx = longint'(fx) - longint'(cur_left);
        dy = longint'(fy) - longint'(cur_top);
        if (!cur_shown || fx >= frm_cols || fy >= frm_rows) return -1;
        if (dx < 0 || dy < 0 || dx >= longint'(cur_cols) || dy >= longint'(cur_rows)) return -1;
        return int'(dy) * EXTENT + int'(dx);
    endfunction

    function automatic logic [31:0] over_blend(input logic [31:0] src, input logic [31:0] dst);
        int unsigned a, inv, ch;
        logic [31:0] res;
        int k;
        a = 32'(src[31:24]);
        if (a == 0) return dst;
        if (a == 255) return src;
        inv = 255 - a;
        res = 32'hff00_0000;
        for (k = 0; k < 3; k++) begin
            ch = 32'(src[8*k +: 8]) + (32'(dst[8*k +: 8]) * inv + 127) / 255;
            if (ch > 255) ch = 255;
            res[8*k +: 8] = ch[7:0];
        end
        return res;
    endfunction

    function automatic t_overlay_px overlay_pixel(input logic [15:0] fx, input logic [15:0] fy,
                                                  input logic [31:0] dst);
        t_overlay_px px;
        int slot;
        slot = cursor_slot(fx, fy);
        px.color   = dst;
        px.covered = 1'b0;
        if (slot >= 0) begin
            px.color   = over_blend(img_word[slot], dst);
            px.covered = 1'b1;
        end
        return px;
    endfunction

    function automatic logic [31:0] random_argb();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(3))
            0: w[31:24] = 8'h00;
            1: w[31:24] = 8'hff;
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] pick_frame();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'd65535;
            2: return $urandom_range(1, 16);
            default: return $urandom_range(1, 65535);
        endcase
    endfunction

    function automatic logic [31:0] pick_edge();
        case ($urandom_range(7))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'(0 - $urandom_range(1, 63));
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'd64;
            2: return 32'd1;
            3: return $urandom_range(65, 127);
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    task automatic dir_row(input t_row_kind kind, input logic [15:0] a, input logic [15:0] b,
                           input logic [31:0] color, input logic typed,
                           input logic [31:0] exp_color, input logic exp_cov);
        plan.push_back('{kind, a, b, color, typed, exp_color, exp_cov});
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        logic ok;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            ok = pready;
            @(posedge i_clk);
        end while (!ok);
        psel    <= 1'b0;
        penable <= 1'b0;
        apply_reg(idx, val);
        n_settings++;
    endtask

    // leaves tvalid high at the accepting edge so the next item can follow back to back
    task automatic send_item(input logic req, input logic [5:0] col, input logic [5:0] row,
                             input logic [15:0] fx, input logic [15:0] fy,
                             input logic [31:0] color, input logic typed,
                             input logic [31:0] exp_color, input logic exp_cov);
        logic ok;
        t_overlay_px px;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0, color, fy, fx, row, col};
        do begin
            @(negedge i_clk);
            ok = o_s_tready;
            @(posedge i_clk);
        end while (!ok);
        n_items++;
        if (req == REQ_LOAD) begin
            img_word[{row, col}] = color;
            img_set[{row, col}]  = 1'b1;
            n_loads++;
        end else begin
            if (typed) px = '{exp_color, exp_cov};
            else px = overlay_pixel(fx, fy, color);
            overlay_q.push_back(px);
        end
    endtask

    // loads give no output, so wait out the pipeline after the last pixel
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (overlay_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_setting();
        logic [31:0] v;
        apb_write(REG_FCOLS, pick_frame());
        apb_write(REG_FROWS, pick_frame());
        apb_write(REG_LEFT, pick_edge());
        apb_write(REG_TOP, pick_edge());
        apb_write(REG_COLS, pick_size());
        apb_write(REG_ROWS, pick_size());
        v = $urandom;
        v[0] = ($urandom_range(99) < 85);
        apb_write(REG_SHOWN, v);
    endtask

    task automatic random_item();
        logic [15:0] fx, fy;
        int off, slot;
        if ($urandom_range(99) < 30) begin
            send_item(REQ_LOAD, 6'($urandom), 6'($urandom), 16'($urandom), 16'($urandom),
                      random_argb(), 1'b0, 32'd0, 1'b0);
        end else begin
            // mostly aim at the cursor rectangle and a few pixels around it
            if ($urandom_range(99) < 75) begin
                off = $urandom_range(32'(cur_cols) + 8);
                fx  = 16'(cur_left + off - 4);
                off = $urandom_range(32'(cur_rows) + 8);
                fy  = 16'(cur_top + off - 4);
            end else begin
                fx = 16'($urandom);
                fy = 16'($urandom);
            end
            slot = cursor_slot(fx, fy);
            if (slot >= 0 && !img_set[slot]) begin
                send_item(REQ_LOAD, 6'(slot % EXTENT), 6'(slot / EXTENT), 16'($urandom),
                          16'($urandom), random_argb(), 1'b0, 32'd0, 1'b0);
            end
            send_item(REQ_BLEND, 6'($urandom), 6'($urandom), fx, fy, $urandom,
                      1'b0, 32'd0, 1'b0);
        end
    endtask

    always @(posedge i_clk) begin
        if (rx_hold) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // long receiver hold-off so the pipeline backs up into the input
    initial begin
        forever begin
            @(hold_kick);
            @(posedge i_clk);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    // outputs are stable by the falling edge; the transaction completes at the next rise
    always @(negedge i_clk) begin
        t_overlay_px want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            n_out++;
            if (o_m_tuser[0]) n_cov++;
            if (overlay_q.size() == 0) begin
                $error("out_color with no pixel pending: actual %h", o_m_tdata);
                err_cnt++;
            end else begin
                want = overlay_q.pop_front();
                if (o_m_tdata !== want.color) begin
                    $error("out_color mismatch: expected %h, actual %h", want.color, o_m_tdata);
                    err_cnt++;
                end
                if (o_m_tuser[0] !== want.covered) begin
                    $error("covered mismatch: expected %0b, actual %0b",
                           want.covered, o_m_tuser[0]);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("timeout after %0d cycles", cyc);
        $display("cursor_overlay_blender_top_tb failed");
        $finish;
    end

    initial begin
        t_row r;
        int i, ph, k, j;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // after reset the cursor is hidden, so everything passes through
        dir_row(ROW_BLEND, 16'd0, 16'd0, 32'h1234_5678, 1, 32'h1234_5678, 0);
        dir_row(ROW_LOAD, 16'd0, 16'd0, 32'hff10_2030, 0, 0, 0);
        dir_row(ROW_LOAD, 16'd63, 16'd63, 32'h00ab_cdef, 0, 0, 0);
        dir_row(ROW_LOAD, 16'd1, 16'd0, 32'h8040_2010, 0, 0, 0);
        dir_row(ROW_LOAD, 16'd2, 16'd0, 32'h7fff_ffff, 0, 0, 0);
        dir_row(ROW_LOAD, 16'd0, 16'd1, 32'h0100_0000, 0, 0, 0);
        dir_row(ROW_LOAD, 16'd63, 16'd0, 32'hfe00_ff00, 0, 0, 0);
        // shown but the frame is still empty
        dir_row(ROW_REG, 16'(REG_SHOWN), 16'd0, 32'd1, 0, 0, 0);
        dir_row(ROW_BLEND, 16'd0, 16'd0, 32'haabb_ccdd, 1, 32'haabb_ccdd, 0);
        dir_row(ROW_REG, 16'(REG_FCOLS), 16'd0, 32'd65535, 0, 0, 0);
        dir_row(ROW_REG, 16'(REG_FROWS), 16'd0, 32'd65535, 0, 0, 0);
        dir_row(ROW_BLEND, 16'd0, 16'd0, 32'h1122_3344, 1, 32'hff10_2030, 1);
        dir_row(ROW_BLEND, 16'd63, 16'd63, 32'h5566_7788, 1, 32'h5566_7788, 1);
        dir_row(ROW_BLEND, 16'd1, 16'd0, 32'hffff_ffff, 0, 0, 0);
        // not premultiplied, channels saturate
        dir_row(ROW_BLEND, 16'd2, 16'd0, 32'hffff_ffff, 0, 0, 0);
        dir_row(ROW_BLEND, 16'd0, 16'd1, 32'h0000_0000, 0, 0, 0);
        dir_row(ROW_BLEND, 16'd64, 16'd0, 32'hdead_beef, 1, 32'hdead_beef, 0);
        dir_row(ROW_BLEND, 16'hffff, 16'hffff, 32'h0123_4567, 1, 32'h0123_4567, 0);
        // cursor in the far corner of the frame
        dir_row(ROW_REG, 16'(REG_LEFT), 16'd0, 32'd65471, 0, 0, 0);
        dir_row(ROW_REG, 16'(REG_TOP), 16'd0, 32'd65471, 0, 0, 0);
        dir_row(ROW_BLEND, 16'hfffe, 16'hfffe, 32'h0102_0304, 1, 32'h0102_0304, 1);
        dir_row(ROW_REG, 16'(REG_LEFT), 16'd0, 32'h8000_0000, 0, 0, 0);
        dir_row(ROW_REG, 16'(REG_TOP), 16'd0, 32'h8000_0000, 0, 0, 0);
        dir_row(ROW_BLEND, 16'd0, 16'd0, 32'hcafe_f00d, 1, 32'hcafe_f00d, 0);
        dir_row(ROW_REG, 16'(REG_LEFT), 16'd0, 32'h7fff_ffff, 0, 0, 0);
        dir_row(ROW_REG, 16'(REG_TOP), 16'd0, 32'h7fff_ffff, 0, 0, 0);
        dir_row(ROW_BLEND, 16'hfffe, 16'hfffe, 32'h0bad_f00d, 1, 32'h0bad_f00d, 0);
        // cursor hanging off the left edge
        dir_row(ROW_REG, 16'(REG_LEFT), 16'd0, 32'hffff_ffff, 0, 0, 0);
        dir_row(ROW_REG, 16'(REG_TOP), 16'd0, 32'd0, 0, 0, 0);
        dir_row(ROW_BLEND, 16'd0, 16'd0, 32'h8765_4321, 0, 0, 0);
        dir_row(ROW_BLEND, 16'd62, 16'd0, 32'ha5a5_a5a5, 0, 0, 0);
        dir_row(ROW_REG, 16'(REG_COLS), 16'd0, 32'd0, 0, 0, 0);
        dir_row(ROW_BLEND, 16'd1, 16'd0, 32'h2468_ace0, 1, 32'h2468_ace0, 0);
        // oversized width clamps, single row
        dir_row(ROW_REG, 16'(REG_LEFT), 16'd0, 32'd0, 0, 0, 0);
        dir_row(ROW_REG, 16'(REG_COLS), 16'd0, 32'd127, 0, 0, 0);
        dir_row(ROW_REG, 16'(REG_ROWS), 16'd0, 32'd1, 0, 0, 0);
        dir_row(ROW_BLEND, 16'd63, 16'd0, 32'h5a5a_5a5a, 0, 0, 0);
        dir_row(ROW_BLEND, 16'd64, 16'd0, 32'h3333_4444, 1, 32'h3333_4444, 0);
        dir_row(ROW_BLEND, 16'd0, 16'd1, 32'h7777_8888, 1, 32'h7777_8888, 0);
        // write to an unmapped register must change nothing
        dir_row(ROW_REG, 16'(REG_UNUSED), 16'd0, 32'hffff_ffff, 0, 0, 0);
        dir_row(ROW_BLEND, 16'd0, 16'd0, 32'h9999_aaaa, 1, 32'hff10_2030, 1);
        dir_row(ROW_REG, 16'(REG_SHOWN), 16'd0, 32'd0, 0, 0, 0);
        dir_row(ROW_BLEND, 16'd0, 16'd0, 32'h1357_9bdf, 1, 32'h1357_9bdf, 0);

        for (i = 0; i < plan.size(); i++) begin
            r = plan[i];
            case (r.kind)
                ROW_REG: begin
                    quiesce();
                    apb_write(r.a[2:0], r.color);
                end
                ROW_LOAD: begin
                    send_item(REQ_LOAD, r.a[5:0], r.b[5:0], 16'($urandom), 16'($urandom),
                              r.color, 1'b0, 32'd0, 1'b0);
                end
                default: begin
                    send_item(REQ_BLEND, 6'($urandom), 6'($urandom), r.a, r.b, r.color,
                              r.typed, r.exp_color, r.exp_cov);
                end
            endcase
        end

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct = 74; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct <= 74; end
                default: begin tx_idle_pct = 21; rx_stall_pct <= 21; end
            endcase
            for (k = 0; k < 4; k++) begin
                quiesce();
                random_setting();
                if (ph == 0 && k == 0) -> hold_kick;
                for (j = 0; j < 90; j++) random_item();
            end
        end

        quiesce();
        $display("%0d input transactions (%0d cursor loads), %0d pixels out, %0d under cursor",
                 n_items, n_loads, n_out, n_cov);
        $display("%0d register writes over four sender/receiver idling phases", n_settings);
        if (err_cnt == 0) begin
            $display("cursor_overlay_blender_top_tb passed");
        end else begin
            $display("cursor_overlay_blender_top_tb failed");
        end
        $finish;
    end

endmodule
